// ----- hdl/gate_schedule_frame_check_macros.svh -----
// ----------------------------------------------------------------------------
// gate schedule frame check assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef GATE_SCHEDULE_FRAME_CHECK_MACROS_SVH
`define GATE_SCHEDULE_FRAME_CHECK_MACROS_SVH

`ifndef ASSERT_OFF
`define GSFC_ASSERT(lbl, clk_sig, rst_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
		else $error("gsfc assertion failed");
`define GSFC_ASSERT_NEVER(lbl, clk_sig, rst_sig, expr) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(expr)) \
		else $error("gsfc forbidden condition seen");
`else
`define GSFC_ASSERT(lbl, clk_sig, rst_sig, prop)
`define GSFC_ASSERT_NEVER(lbl, clk_sig, rst_sig, expr)
`endif

`endif

// ----- hdl/gsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// gsfc_pkg
// shared types and constants of the gate schedule frame check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsfc_pkg;

	localparam int GSFC_LIST_DEPTH = 64;

	localparam int TS_W      = 64;
	localparam int BASE_W    = 63;
	localparam int CYC_W     = 38;
	localparam int MASK_W    = 32;
	localparam int LEN_W     = 32;
	localparam int ENT_W     = 7;
	localparam int IDX_OUT_W = 6;
	localparam int TC_W      = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;
	localparam int DIV_STEPS = 64;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCHED_START    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd1;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [LEN_W-1:0]  interval;
	} entry_t;

	typedef struct packed {
		logic              start;
		logic [TS_W-1:0]   dividend;
		logic [CYC_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [CYC_W-1:0]  rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SUM,
		ST_LEN,
		ST_DIV,
		ST_WALK,
		ST_WRAP,
		ST_FIN
	} state_t;

endpackage

// ----- hdl/gsfc_list_mem.sv -----
// ----------------------------------------------------------------------------
// gsfc_list_mem
// gate control list storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsfc_list_mem
	import gsfc_pkg::*;
#(
	parameter int DEPTH = GSFC_LIST_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/gsfc_rem_div.sv -----
// ----------------------------------------------------------------------------
// gsfc_rem_div
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gate_schedule_frame_check_macros.svh"

module gsfc_rem_div
	import gsfc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic [TS_W-1:0]  dvd_q;
	logic [CYC_W-1:0] dsr_q;
	logic [CYC_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CYC_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, dvd_q[TS_W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TS_W-2:0], 1'b0};
			rem_q <= fits ? CYC_W'(shifted - {1'b0, dsr_q}) : CYC_W'(shifted);
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

	`GSFC_ASSERT(a_start_sets_busy, clk, arst_n, req.start |=> busy_q)
	`GSFC_ASSERT_NEVER(a_start_while_busy, clk, arst_n, req.start && busy_q)
	`GSFC_ASSERT(a_rem_below_divisor, clk, arst_n, done_q |-> (rem_q < dsr_q))

endmodule

// ----- hdl/gate_schedule_frame_check.sv -----
// ----------------------------------------------------------------------------
// gate_schedule_frame_check
// A load transfer (func 0) writes one gate list entry and marks the cycle
// time stale; the next transfer can follow in the next cycle. A frame
// transfer (func 1) compares the timestamp with the schedule start in
// ST_CHECK, then, only when the cycle time is stale, sums the intervals of
// the entries in use through the single list memory read port (ST_SUM),
// tests for a zero cycle time, which posts a fault (ST_LEN), takes the
// remainder of the elapsed time over all 64 dividend bits in the remainder
// unit (ST_DIV), walks the entries to the active window (ST_WALK, at most
// the entries in use, as the remainder is below the cycle time) and posts
// the result (ST_FIN); the idle state then takes the next transfer. The
// entry count in use is entries_in_use held between 1 and the list depth.
// A frame at or before the schedule start gives no result. The posting
// state waits while the output register holds a result not yet taken; no
// transfer is accepted while it waits there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gate_schedule_frame_check_macros.svh"

module gate_schedule_frame_check
	import gsfc_pkg::*;
#(
	parameter int LIST_DEPTH = GSFC_LIST_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [IDX_OUT_W-1:0] entry_index,
	input  logic [MASK_W-1:0]    gate_mask,
	input  logic [LEN_W-1:0]     interval,
	input  logic [TS_W-1:0]      timestamp,
	input  logic [TC_W-1:0]      traffic_class,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 on_time,
	output logic [TS_W-1:0]      window_start,
	output logic [LEN_W-1:0]     offset,
	output logic [MASK_W-1:0]    active_mask,
	output logic [IDX_OUT_W-1:0] active_index,
	output logic                 fault,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	state_t state_q, state_d;

	logic [BASE_W-1:0] base_q;
	logic [ENT_W-1:0]  entries_q;
	logic              cycle_known_q;
	logic [CYC_W-1:0]  cycle_len_q;
	logic [CYC_W-1:0]  sum_q;
	logic [TS_W-1:0]   ts_q;
	logic [TC_W-1:0]   tc_q;
	logic [TS_W-1:0]   diff_q;
	logic [CYC_W-1:0]  rem_q;
	logic [IDX_W-1:0]  cur_q;
	logic [MASK_W-1:0] res_mask_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_fault_q;
	logic              out_valid_q;

	logic [CNT_W-1:0]  count;
	logic              in_xfer;
	logic              cfg_xfer;
	logic              load_xfer;
	logic              ts_after_base;
	logic              last_entry;
	logic              window_hit;
	logic              out_free;
	logic              mem_wr_en;
	logic              mem_rd_en;
	logic [IDX_W-1:0]  mem_rd_addr;
	entry_t            mem_wr_data;
	entry_t            mem_rd_data;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign cfg_ready     = 1'b1;
	assign cfg_xfer      = cfg_valid && cfg_ready;
	assign in_xfer       = in_valid && in_ready;
	assign load_xfer     = in_xfer && (func == FUNC_LOAD);
	assign ts_after_base = ts_q > {1'b0, base_q};
	assign last_entry    = (CNT_W'(cur_q) + CNT_W'(1)) == count;
	assign window_hit    = CYC_W'(mem_rd_data.interval) > rem_q;
	assign out_free      = !out_valid_q || out_ready;

	always_comb begin
		if (entries_q == '0) begin
			count = CNT_W'(1);
		end else if (32'(entries_q) > LIST_DEPTH) begin
			count = CNT_W'(LIST_DEPTH);
		end else begin
			count = CNT_W'(entries_q);
		end
	end

	// gate list memory
	assign mem_wr_en            = load_xfer && (32'(entry_index) < LIST_DEPTH);
	assign mem_wr_data.mask     = gate_mask;
	assign mem_wr_data.interval = interval;

	gsfc_list_mem #(
		.DEPTH (LIST_DEPTH),
		.AW    (IDX_W)
	) u_list_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (IDX_W'(entry_index)),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	gsfc_rem_div u_rem_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req.dividend = diff_q;
	assign div_req.divisor  = cycle_len_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer && (func == FUNC_CHECK)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!ts_after_base) begin
					state_d = ST_IDLE;
				end else if (cycle_known_q) begin
					state_d = ST_LEN;
				end else begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (last_entry) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				state_d = (cycle_len_q == '0) ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (window_hit) begin
					state_d = ST_FIN;
				end else if (last_entry) begin
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		in_ready      = 1'b0;
		mem_rd_en     = 1'b0;
		mem_rd_addr   = '0;
		div_req.start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_CHECK: begin
				mem_rd_en = ts_after_base && !cycle_known_q;
			end
			ST_SUM: begin
				mem_rd_en   = !last_entry;
				mem_rd_addr = cur_q + 1'b1;
			end
			ST_LEN: begin
				div_req.start = cycle_len_q != '0;
			end
			ST_DIV: begin
				mem_rd_en = div_rsp.done;
			end
			ST_WALK: begin
				mem_rd_en   = !window_hit;
				mem_rd_addr = last_entry ? '0 : cur_q + 1'b1;
			end
			ST_WRAP, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers and cycle time cache
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= '0;
			entries_q     <= ENT_W'(1);
			cycle_known_q <= 1'b0;
			cycle_len_q   <= '0;
		end else begin
			if (cfg_xfer) begin
				unique case (cfg_index)
					REG_SCHED_START:    base_q    <= cfg_data[BASE_W-1:0];
					REG_ENTRIES_IN_USE: entries_q <= cfg_data[ENT_W-1:0];
					default: begin
					end
				endcase
			end
			if ((cfg_xfer && (cfg_index == REG_ENTRIES_IN_USE)) || load_xfer) begin
				cycle_known_q <= 1'b0;
			end else if ((state_q == ST_SUM) && last_entry) begin
				cycle_known_q <= 1'b1;
				cycle_len_q   <= sum_q + CYC_W'(mem_rd_data.interval);
			end
		end
	end

	// frame datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ts_q <= timestamp;
			tc_q <= traffic_class;
		end
		case (state_q)
			ST_CHECK: begin
				diff_q <= ts_q - {1'b0, base_q};
				sum_q  <= '0;
				cur_q  <= '0;
			end
			ST_SUM: begin
				sum_q <= sum_q + CYC_W'(mem_rd_data.interval);
				cur_q <= cur_q + 1'b1;
			end
			ST_LEN: begin
				res_fault_q <= cycle_len_q == '0;
			end
			ST_DIV: begin
				rem_q <= div_rsp.rem;
				cur_q <= '0;
			end
			ST_WALK: begin
				if (window_hit) begin
					res_mask_q <= mem_rd_data.mask;
					res_idx_q  <= cur_q;
				end else begin
					rem_q <= rem_q - CYC_W'(mem_rd_data.interval);
					cur_q <= last_entry ? '0 : cur_q + 1'b1;
				end
			end
			ST_WRAP: begin
				res_mask_q <= mem_rd_data.mask;
				res_idx_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			if (res_fault_q) begin
				on_time      <= 1'b0;
				window_start <= '0;
				offset       <= '0;
				active_mask  <= '0;
				active_index <= '0;
				fault        <= 1'b1;
			end else begin
				on_time      <= res_mask_q[{1'b0, tc_q}];
				window_start <= ts_q - TS_W'(rem_q);
				offset       <= rem_q[LEN_W-1:0];
				active_mask  <= res_mask_q;
				active_index <= IDX_OUT_W'(res_idx_q);
				fault        <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`GSFC_ASSERT(a_walk_idx_in_use, clk, arst_n, (state_q == ST_WALK) |-> (CNT_W'(cur_q) < count))
	`GSFC_ASSERT(a_walk_rem_in_cycle, clk, arst_n, (state_q == ST_WALK) |-> (rem_q < cycle_len_q))
	`GSFC_ASSERT(a_div_needs_cycle, clk, arst_n, (state_q == ST_DIV) |-> (cycle_known_q && (cycle_len_q != '0)))

endmodule

// ----- bench/gate_schedule_frame_check_tb.sv -----
// ----------------------------------------------------------------------------
// gate_schedule_frame_check_tb
// Self-checking bench for the gate control list frame checker. A short
// directed list covers fault, base time and entry count extremes, then random
// loads and frames over many schedule settings are checked against a local
// gate list lookup, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gate_schedule_frame_check_tb;
	import gsfc_pkg::*;

	localparam int PHASES        = 12;
	localparam int PER_PHASE     = 100;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_OFF      = 600;
	localparam int STUCK_LIMIT   = 5000;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;
	localparam logic [BASE_W-1:0]    BASE_MAX        = '1;

	typedef struct packed {
		logic                 func;
		logic [IDX_OUT_W-1:0] idx;
		logic [MASK_W-1:0]    mask;
		logic [LEN_W-1:0]     len;
		logic [TS_W-1:0]      ts;
		logic [TC_W-1:0]      tc;
	} gate_item_t;

	typedef struct packed {
		logic                 on_time;
		logic [TS_W-1:0]      window_start;
		logic [LEN_W-1:0]     offset;
		logic [MASK_W-1:0]    active_mask;
		logic [IDX_OUT_W-1:0] active_index;
		logic                 fault;
	} gate_verdict_t;

	typedef struct packed {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_DAT_W-1:0] reg_val;
		gate_item_t           item;
		bit                   typed;
		gate_verdict_t        want;
	} probe_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 func;
	logic [IDX_OUT_W-1:0] entry_index;
	logic [MASK_W-1:0]    gate_mask;
	logic [LEN_W-1:0]     interval;
	logic [TS_W-1:0]      timestamp;
	logic [TC_W-1:0]      traffic_class;
	logic                 out_valid;
	logic                 out_ready;
	logic                 on_time;
	logic [TS_W-1:0]      window_start;
	logic [LEN_W-1:0]     offset;
	logic [MASK_W-1:0]    active_mask;
	logic [IDX_OUT_W-1:0] active_index;
	logic                 fault;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// gate list copy kept by the bench
	logic [MASK_W-1:0] sched_mask [GSFC_LIST_DEPTH];
	logic [LEN_W-1:0]  sched_len [GSFC_LIST_DEPTH];
	logic [CYC_W-1:0]  cycle_ns    = '0;
	bit                cycle_valid = 1'b0;
	logic [BASE_W-1:0] base_ns     = '0;
	logic [ENT_W-1:0]  entries_cfg = 7'd1;

	gate_verdict_t verdicts [$];
	int            fails        = 0;
	bit            idle_on      = 1'b1;
	bit            hold_off_req = 1'b0;

	gate_schedule_frame_check DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.entry_index   (entry_index),
		.gate_mask     (gate_mask),
		.interval      (interval),
		.timestamp     (timestamp),
		.traffic_class (traffic_class),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.on_time       (on_time),
		.window_start  (window_start),
		.offset        (offset),
		.active_mask   (active_mask),
		.active_index  (active_index),
		.fault         (fault),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int used_entries();
		if (entries_cfg == 0)
			return 1;
		if (entries_cfg > GSFC_LIST_DEPTH)
			return GSFC_LIST_DEPTH;
		return int'(entries_cfg);
	endfunction

	function automatic logic [63:0] len_prefix(input int k);
		logic [63:0] sum;
		sum = '0;
		for (int i = 0; i < k; i++)
			sum += 64'(sched_len[i]);
		return sum;
	endfunction

	function automatic bit schedule_lookup(input logic [TS_W-1:0] ts, input logic [TC_W-1:0] tc,
			output gate_verdict_t v);
		logic [63:0] sum, n, now, len, base64, cyc64;
		int cnt, cur;
		v = '0;
		base64 = 64'(base_ns);
		if (ts <= base64)
			return 1'b0;
		cnt = used_entries();
		if (!cycle_valid) begin
			sum = len_prefix(cnt);
			cycle_ns = sum[CYC_W-1:0];
			cycle_valid = 1'b1;
		end
		if (cycle_ns == 0) begin
			v.fault = 1'b1;
			return 1'b1;
		end
		cyc64 = 64'(cycle_ns);
		n = (ts - base64) / cyc64;
		now = base64 + n * cyc64;
		cur = 0;
		for (int i = 0; i < cnt; i++) begin
			len = 64'(sched_len[cur]);
			if (len > ts - now)
				break;
			now += len;
			cur++;
			if (cur >= cnt)
				cur = 0;
		end
		len = ts - now;
		v.on_time = sched_mask[cur][tc];
		v.window_start = now;
		v.offset = len[LEN_W-1:0];
		v.active_mask = sched_mask[cur];
		v.active_index = IDX_OUT_W'(cur);
		return 1'b1;
	endfunction

	function automatic gate_item_t load_item(input logic [IDX_OUT_W-1:0] idx,
			input logic [MASK_W-1:0] mask, input logic [LEN_W-1:0] len);
		gate_item_t it;
		it.func = FUNC_LOAD;
		it.idx = idx;
		it.mask = mask;
		it.len = len;
		it.ts = {$urandom, $urandom};
		it.tc = TC_W'($urandom);
		return it;
	endfunction

	function automatic gate_item_t frame_item(input logic [TS_W-1:0] ts, input logic [TC_W-1:0] tc);
		gate_item_t it;
		it.func = FUNC_CHECK;
		it.idx = IDX_OUT_W'($urandom);
		it.mask = $urandom;
		it.len = $urandom;
		it.ts = ts;
		it.tc = tc;
		return it;
	endfunction

	function automatic gate_verdict_t verdict(input logic on, input logic [TS_W-1:0] ws,
			input logic [LEN_W-1:0] off, input logic [MASK_W-1:0] mask,
			input logic [IDX_OUT_W-1:0] idx, input logic flt);
		gate_verdict_t v;
		v.on_time = on;
		v.window_start = ws;
		v.offset = off;
		v.active_mask = mask;
		v.active_index = idx;
		v.fault = flt;
		return v;
	endfunction

	function automatic probe_t step_row(input gate_item_t it);
		probe_t r;
		r = '0;
		r.item = it;
		return r;
	endfunction

	function automatic probe_t typed_row(input gate_item_t it, input gate_verdict_t want);
		probe_t r;
		r = '0;
		r.item = it;
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic probe_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] val);
		probe_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] pick_interval();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return LEN_W'($urandom_range(1, 64));
			5, 6: return LEN_W'($urandom_range(1, 5000));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly lands inside or on the edge of a window, sometimes pure noise
	function automatic logic [TS_W-1:0] frame_time();
		logic [63:0] room, d, win, cyc;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return 64'(base_ns) - ({$urandom, $urandom} >> $urandom_range(0, 63));
		if (pick < 12)
			return {$urandom, $urandom};
		room = ~64'(base_ns);
		d = {$urandom, $urandom} >> $urandom_range(0, 63);
		if (d == 0)
			d = 1;
		if (d > room)
			d = room;
		cyc = len_prefix(used_entries());
		if (cyc != 0 && pick < 60) begin
			win = d - d % cyc + len_prefix($urandom_range(0, used_entries() - 1))
				+ 64'($urandom_range(0, 2)) - 64'd1;
			if (win != 0 && win <= room)
				d = win;
		end
		return 64'(base_ns) + d;
	endfunction

	task automatic offer(input gate_item_t it, input bit typed, input gate_verdict_t want,
			output bit counted);
		gate_verdict_t got;
		bit has;
		in_valid <= 1'b1;
		func <= it.func;
		entry_index <= it.idx;
		gate_mask <= it.mask;
		interval <= it.len;
		timestamp <= it.ts;
		traffic_class <= it.tc;
		do @(posedge clk); while (in_ready !== 1'b1);
		has = 1'b0;
		if (it.func == FUNC_LOAD) begin
			sched_mask[it.idx] = it.mask;
			sched_len[it.idx] = it.len;
			cycle_valid = 1'b0;
		end else begin
			has = schedule_lookup(it.ts, it.tc, got);
		end
		if (has)
			verdicts.push_back(typed ? want : got);
		counted = has || (it.func == FUNC_LOAD);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_SCHED_START: base_ns = val[BASE_W-1:0];
			REG_ENTRIES_IN_USE: begin
				entries_cfg = val[ENT_W-1:0];
				cycle_valid = 1'b0;
			end
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic maybe_pause();
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		gate_verdict_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (verdicts.size() == 0) begin
				$error("result transfer with no frame pending");
				fails++;
			end else begin
				want = verdicts.pop_front();
				check_field("on_time", 64'(want.on_time), 64'(on_time));
				check_field("window_start", want.window_start, window_start);
				check_field("offset", 64'(want.offset), 64'(offset));
				check_field("active_mask", 64'(want.active_mask), 64'(active_mask));
				check_field("active_index", 64'(want.active_index), 64'(active_index));
				check_field("fault", 64'(want.fault), 64'(fault));
			end
		end
	end

	initial begin : result_sink
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
		$error("no transfer for %0d cycles", STUCK_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		probe_t            probe_rows [$];
		gate_item_t        it;
		bit                counted;
		int                done_cnt, sent;
		logic [ENT_W-1:0]  ent;
		logic [BASE_W-1:0] base;
		logic [63:0]       regval;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_LOAD;
		entry_index <= '0;
		gate_mask <= '0;
		interval <= '0;
		timestamp <= '0;
		traffic_class <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SCHED_START;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: one entry in use, base time zero
		probe_rows.push_back(step_row(frame_item(64'd0, 4'd0)));
		probe_rows.push_back(step_row(load_item(6'd0, 32'h0, 32'h0)));
		probe_rows.push_back(typed_row(frame_item(64'd1, 4'd0), verdict(0, 0, 0, 0, 0, 1)));
		probe_rows.push_back(step_row(load_item(6'd0, '1, '1)));
		probe_rows.push_back(typed_row(frame_item('1, 4'd15), verdict(1, '1, 0, '1, 0, 0)));
		probe_rows.push_back(step_row(load_item(6'd63, 32'h8000_0001, 32'd5)));
		probe_rows.push_back(step_row(load_item(6'd1, 32'h0, 32'h0)));
		probe_rows.push_back(step_row(load_item(6'd2, 32'h0000_0100, 32'd10)));
		probe_rows.push_back(reg_row(REG_ENTRIES_IN_USE, 64'd3));
		// zero length entry skipped on the way to entry 2
		probe_rows.push_back(typed_row(frame_item(64'h0000_0000_FFFF_FFFF, 4'd8),
			verdict(1, 64'hFFFF_FFFF, 0, 32'h0000_0100, 6'd2, 0)));
		probe_rows.push_back(typed_row(frame_item(64'd5, 4'd15), verdict(1, 0, 5, '1, 0, 0)));
		probe_rows.push_back(typed_row(frame_item(64'h0000_0002_0000_000B, 4'd0),
			verdict(0, 64'h0000_0002_0000_0008, 3, 32'h0000_0100, 6'd2, 0)));
		probe_rows.push_back(step_row(frame_item(64'h0000_0001_0000_0008, 4'd3)));
		probe_rows.push_back(reg_row(REG_SCHED_START, '1));
		probe_rows.push_back(step_row(frame_item(64'h7FFF_FFFF_FFFF_FFFF, 4'd1)));
		probe_rows.push_back(typed_row(frame_item(64'h8000_0000_0000_0000, 4'd0),
			verdict(1, 64'h7FFF_FFFF_FFFF_FFFF, 1, '1, 0, 0)));
		probe_rows.push_back(step_row(frame_item('1, 4'd8)));
		// entry count of zero acts as one
		probe_rows.push_back(reg_row(REG_ENTRIES_IN_USE, 64'hFFFF_FFFF_FFFF_FF80));
		probe_rows.push_back(typed_row(frame_item(64'h8000_0000_0000_0005, 4'd3),
			verdict(1, 64'h7FFF_FFFF_FFFF_FFFF, 6, '1, 0, 0)));
		probe_rows.push_back(reg_row(REG_UNMAPPED_LO, '1));
		probe_rows.push_back(reg_row(REG_UNMAPPED_HI, '0));
		probe_rows.push_back(step_row(frame_item(64'hC000_0000_0000_0000, 4'd9)));
		probe_rows.push_back(reg_row(REG_SCHED_START, '0));
		probe_rows.push_back(step_row(load_item(6'd1, 32'h0000_0200, 32'd7)));
		probe_rows.push_back(typed_row(frame_item(64'd100, 4'd9), verdict(1, 0, 100, '1, 0, 0)));

		foreach (probe_rows[i]) begin
			if (probe_rows[i].is_reg) begin
				settle();
				write_reg(probe_rows[i].reg_idx, probe_rows[i].reg_val);
			end else begin
				offer(probe_rows[i].item, probe_rows[i].typed, probe_rows[i].want, counted);
				maybe_pause();
			end
		end

		// fill the whole list so every entry count is legal
		for (int k = 0; k < GSFC_LIST_DEPTH; k++) begin
			offer(load_item(IDX_OUT_W'(k), pick_mask(), pick_interval()), 1'b0, '0, counted);
			maybe_pause();
		end

		for (int p = 0; p < PHASES; p++) begin
			idle_on = (p < PHASES - 2) && (p != 7);
			settle();
			case (p)
				0: begin ent = 7'd64; base = '0; end
				1: begin ent = 7'd1; base = BASE_MAX; end
				2: begin ent = 7'd127; base = 63'd1; end
				3: begin ent = 7'd0; base = BASE_W'({$urandom, $urandom}); end
				4: begin ent = 7'd65; base = BASE_MAX; end
				default: begin
					ent = ($urandom_range(0, 2) == 0) ? ENT_W'($urandom_range(1, 64))
						: ENT_W'($urandom_range(1, 8));
					base = ($urandom_range(0, 1) == 0) ? BASE_W'({$urandom, $urandom})
						: BASE_W'($urandom_range(0, 100000));
				end
			endcase
			regval = {$urandom, $urandom};
			regval[ENT_W-1:0] = ent;
			write_reg(REG_ENTRIES_IN_USE, regval);
			regval = {$urandom, $urandom};
			regval[BASE_W-1:0] = base;
			write_reg(REG_SCHED_START, regval);

			if (p == 3)
				hold_off_req = 1'b1;
			done_cnt = 0;
			sent = 0;
			while (done_cnt < PER_PHASE) begin
				if ($urandom_range(0, 99) < 15)
					it = load_item(IDX_OUT_W'($urandom), pick_mask(), pick_interval());
				else
					it = frame_item(frame_time(), TC_W'($urandom));
				offer(it, 1'b0, '0, counted);
				done_cnt += int'(counted);
				sent++;
				if (p == 6 && sent == 40)
					drain();
				else
					maybe_pause();
			end
		end

		settle();
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
